@@ rtl/core/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the capacity reservation tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PROFILE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_CAP    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [31:0] CAP_RESET = 32'd1073741824;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,      // capture the command beat
    OP_RESERVE,    // write new entry, update counters
    OP_SCAN_RD,    // issue table read at scan index
    OP_SCAN_CHK,   // compare id / compute byte-ticks product (multiply)
    OP_SCAN_ACC,   // add product to total
    OP_MOVE_RD,    // read last entry
    OP_MOVE_WR,    // write last entry into hit slot, finish release
    OP_DIV1_INIT,
    OP_DIV_STEP,
    OP_DIV2_INIT,
    OP_PROF_DONE,
    OP_EMIT
  } crt_op_e;

  typedef struct packed {
    crt_op_e op;
  } crt_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       no_cap;
    logic       full;
    logic       empty;
    logic       scan_end;
    logic       hit;
    logic       div_done;
  } crt_stat_t;

endpackage

@@ rtl/core/crt_datapath.sv @@
// ----------------------------------------------------------------------------
// crt_datapath
// Reservation table, counters, byte-tick integral and a radix-2 divider.
// ----------------------------------------------------------------------------
module crt_datapath import crt_pkg::*; #(
  parameter int MaxRes = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_i,
  input  logic [31:0] req_bytes_i,
  input  logic [31:0] res_id_i,
  input  crt_cmd_t    ctl_i,
  output crt_stat_t   stat_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_id_o,
  output logic [31:0] avg_bytes_o,
  output logic [16:0] util_ratio_o,
  output logic [31:0] free_bytes_o
);

  localparam int IdxW = $clog2(MaxRes);
  localparam int CntW = $clog2(MaxRes + 1);

  logic [31:0] mem_id    [MaxRes];
  logic [31:0] mem_start [MaxRes];
  logic [31:0] mem_bytes [MaxRes];

  logic [31:0] cap_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0] inuse_q, last_prof_q, next_id_q;
  logic [63:0] sum_q;

  logic [1:0]  cmd_q;
  logic [31:0] now_q, req_q, rid_q;

  logic [CntW-1:0] scan_q;
  logic [IdxW-1:0] hit_idx_q;
  logic            hit_q;
  logic [31:0] rd_id_q, rd_start_q, rd_bytes_q;
  logic [63:0] prod_q, total_q;

  // bytes of the hit slot, captured when the hit is found
  logic [31:0] rd_bytes_hit_q;

  logic [63:0] quo_q, rem_q, dvs_q;
  logic [6:0]  div_cnt_q;
  logic        div2_q;

  logic [2:0]  status_q;
  logic [31:0] granted_q, avg_q;
  logic [16:0] ratio_q;

  logic [31:0] free_w;
  logic [31:0] from_w;
  logic [31:0] dt_w;
  logic [64:0] acc_w;
  logic [64:0] rem_sh_w;
  logic [IdxW-1:0] last_idx_w;

  assign free_w     = (inuse_q > cap_q) ? 32'd0 : cap_q - inuse_q;
  assign from_w     = (last_prof_q > rd_start_q) ? last_prof_q : rd_start_q;
  assign dt_w       = (now_q > from_w) ? now_q - from_w : 32'd0;
  assign acc_w      = {1'b0, total_q} + {1'b0, prod_q};
  assign rem_sh_w   = {rem_q, quo_q[63]};
  assign last_idx_w = IdxW'(cnt_q - CntW'(1));

  assign stat_o.cmd      = cmd_q;
  assign stat_o.no_cap   = req_q > free_w;
  assign stat_o.full     = cnt_q >= CntW'(MaxRes);
  assign stat_o.empty    = now_q <= last_prof_q;
  assign stat_o.scan_end = scan_q >= cnt_q;
  assign stat_o.hit      = hit_q;
  assign stat_o.div_done = div_cnt_q == 7'd0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_RESERVE) begin
      mem_id[cnt_q[IdxW-1:0]]    <= next_id_q;
      mem_start[cnt_q[IdxW-1:0]] <= now_q;
      mem_bytes[cnt_q[IdxW-1:0]] <= req_q;
    end else if (ctl_i.op == OP_MOVE_WR && hit_idx_q != last_idx_w) begin
      mem_id[hit_idx_q]    <= rd_id_q;
      mem_start[hit_idx_q] <= rd_start_q;
      mem_bytes[hit_idx_q] <= rd_bytes_q;
    end
    if (ctl_i.op == OP_SCAN_RD) begin
      rd_id_q    <= mem_id[scan_q[IdxW-1:0]];
      rd_start_q <= mem_start[scan_q[IdxW-1:0]];
      rd_bytes_q <= mem_bytes[scan_q[IdxW-1:0]];
    end else if (ctl_i.op == OP_MOVE_RD) begin
      rd_id_q    <= mem_id[last_idx_w];
      rd_start_q <= mem_start[last_idx_w];
      rd_bytes_q <= mem_bytes[last_idx_w];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LATCH: begin
        cmd_q <= cmd_i;
        now_q <= now_i;
        req_q <= req_bytes_i;
        rid_q <= res_id_i;
      end
      OP_SCAN_CHK: prod_q <= 64'(dt_w) * 64'(rd_bytes_q);
      OP_DIV1_INIT: begin
        quo_q <= total_q;
        rem_q <= '0;
        dvs_q <= {32'd0, now_q - last_prof_q};
      end
      OP_DIV2_INIT: begin
        quo_q <= {16'd0, avg_q, 16'd0};
        rem_q <= '0;
        dvs_q <= {32'd0, cap_q};
      end
      OP_DIV_STEP: begin
        if (rem_sh_w >= {1'b0, dvs_q}) begin
          rem_q <= 64'(rem_sh_w - {1'b0, dvs_q});
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh_w[63:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      inuse_q     <= '0;
      sum_q       <= '0;
      last_prof_q <= '0;
      next_id_q   <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      total_q     <= '0;
      div_cnt_q   <= '0;
      div2_q      <= 1'b0;
      status_q    <= ST_OK;
      granted_q   <= '0;
      avg_q       <= '0;
      ratio_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      unique case (ctl_i.op)
        OP_LATCH: begin
          scan_q    <= '0;
          hit_q     <= 1'b0;
          total_q   <= sum_q;
          granted_q <= '0;
          avg_q     <= '0;
          ratio_q   <= '0;
          // reserve and profile outcomes are fixed by the state at accept
          if (cmd_i == CMD_RESERVE && req_bytes_i > free_w) begin
            status_q <= ST_NO_CAP;
          end else if (cmd_i == CMD_RESERVE && stat_o.full) begin
            status_q <= ST_FULL;
          end else if (cmd_i == CMD_PROFILE && now_i <= last_prof_q) begin
            status_q <= ST_EMPTY;
          end else begin
            status_q <= ST_OK;
          end
        end
        OP_RESERVE: begin
          granted_q <= next_id_q;
          next_id_q <= next_id_q + 32'd1;
          cnt_q     <= cnt_q + CntW'(1);
          inuse_q   <= inuse_q + req_q;
        end
        OP_SCAN_CHK: begin
          if (cmd_q == CMD_RELEASE && rd_id_q == rid_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= scan_q[IdxW-1:0];
          end else begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        OP_SCAN_ACC: begin
          if (cmd_q == CMD_PROFILE || hit_q) begin
            total_q <= acc_w[64] ? '1 : acc_w[63:0];
          end
        end
        OP_MOVE_WR: begin
          sum_q   <= total_q;
          inuse_q <= (rd_bytes_hit_q > inuse_q) ? 32'd0 : inuse_q - rd_bytes_hit_q;
          cnt_q   <= cnt_q - CntW'(1);
        end
        OP_DIV1_INIT: begin
          div_cnt_q <= 7'd64;
          div2_q    <= 1'b0;
        end
        OP_DIV2_INIT: begin
          div_cnt_q <= 7'd64;
          div2_q    <= 1'b1;
        end
        OP_DIV_STEP: div_cnt_q <= div_cnt_q - 7'd1;
        OP_PROF_DONE: begin
          if (div2_q) begin
            ratio_q <= (quo_q > 64'd65536) ? 17'd65536 : quo_q[16:0];
          end else begin
            avg_q <= (quo_q[63:32] != 32'd0) ? '1 : quo_q[31:0];
            if (cap_q == 32'd0) begin
              ratio_q <= 17'd65536;
            end
          end
          sum_q       <= '0;
          last_prof_q <= now_q;
        end
        default: ;
      endcase
      if (ctl_i.op == OP_EMIT && stat_o.cmd == CMD_RELEASE && !hit_q) begin
        status_q <= ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_SCAN_CHK && rd_id_q == rid_q) begin
      rd_bytes_hit_q <= rd_bytes_q;
    end
  end

  assign status_o     = status_q;
  assign granted_id_o = granted_q;
  assign avg_bytes_o  = avg_q;
  assign util_ratio_o = ratio_q;
  assign free_bytes_o = free_w;

endmodule

@@ rtl/core/crt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer for reserve, release-scan-move and profile-scan-divide.
// ----------------------------------------------------------------------------
module crt_ctrl import crt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  crt_stat_t stat_i,
  output crt_cmd_t  ctl_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_CHK, S_ACC, S_MVRD, S_MVWR,
    S_D1I, S_DIV, S_D2I, S_PDONE, S_EMIT, S_OUT
  } state_e;

  state_e state_q;
  logic   div2_q;
  logic   done_q;

  always_comb begin
    unique case (state_q)
      S_IDLE:   ctl_o.op = start_i ? OP_LATCH : OP_NONE;
      S_DECODE: ctl_o.op = (stat_i.cmd == CMD_RESERVE && !stat_i.no_cap && !stat_i.full)
                           ? OP_RESERVE : OP_NONE;
      S_RD:     ctl_o.op = stat_i.scan_end ? OP_NONE : OP_SCAN_RD;
      S_CHK:    ctl_o.op = OP_SCAN_CHK;
      S_ACC:    ctl_o.op = OP_SCAN_ACC;
      S_MVRD:   ctl_o.op = OP_MOVE_RD;
      S_MVWR:   ctl_o.op = OP_MOVE_WR;
      S_D1I:    ctl_o.op = OP_DIV1_INIT;
      S_DIV:    ctl_o.op = stat_i.div_done ? OP_NONE : OP_DIV_STEP;
      S_D2I:    ctl_o.op = OP_DIV2_INIT;
      S_PDONE:  ctl_o.op = OP_PROF_DONE;
      S_EMIT:   ctl_o.op = OP_EMIT;
      default:  ctl_o.op = OP_NONE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      div2_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (stat_i.cmd == CMD_RELEASE) begin
            state_q <= S_RD;
          end else if (stat_i.cmd == CMD_PROFILE && !stat_i.empty) begin
            state_q <= S_RD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_RD: begin
          if (stat_i.scan_end) begin
            state_q <= (stat_i.cmd == CMD_PROFILE) ? S_D1I : S_EMIT;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: state_q <= S_ACC;
        S_ACC: state_q <= stat_i.hit ? S_MVRD : S_RD;
        S_MVRD: state_q <= S_MVWR;
        S_MVWR: state_q <= S_EMIT;
        S_D1I: begin
          div2_q  <= 1'b0;
          state_q <= S_DIV;
        end
        S_DIV: if (stat_i.div_done) state_q <= S_PDONE;
        S_PDONE: state_q <= div2_q ? S_EMIT : S_D2I;
        S_D2I: begin
          div2_q  <= 1'b1;
          state_q <= S_DIV;
        end
        S_EMIT: begin
          state_q <= S_OUT;
          done_q  <= 1'b1;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/capacity_reservation_tracker_core.sv @@
// ----------------------------------------------------------------------------
// capacity_reservation_tracker_core
// Byte capacity admission, reservation table and occupancy profiling.
// ----------------------------------------------------------------------------
// channel  | ports                                   | handshake
// command  | cmd_i now_i req_bytes_i res_id_i        | start_i && !busy_o
// result   | status_o granted_id_o avg_bytes_o ...   | done_o, one cycle
// config   | cap_we_i cap_wdata_i                    | cap_we_i
//
// Reserve: latch, decode, reserve, emit. Release: latch, decode, scan for the id,
// then on a hit a move of the last entry into that slot. Profile: latch, decode,
// a scan of all live slots, then two 64-step divisions through one shared
// restoring divider; the scan uses a single read port and a 32x32 multiplier.
// Reset is asynchronous; the table itself is not cleared, only the count.
// Results cannot be stalled; busy_o stays high until the result cycle ends.
// ----------------------------------------------------------------------------
module capacity_reservation_tracker_core import crt_pkg::*; #(
  parameter int MAX_RESERVATIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cap_we_i,
  input  logic [31:0] cap_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_i,
  input  logic [31:0] req_bytes_i,
  input  logic [31:0] res_id_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_id_o,
  output logic [31:0] avg_bytes_o,
  output logic [16:0] util_ratio_o,
  output logic [31:0] free_bytes_o
);

  crt_cmd_t  ctl;
  crt_stat_t stat;

  crt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctl_o  (ctl),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  crt_datapath #(.MaxRes(MAX_RESERVATIONS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cap_we_i),
    .cfg_wdata_i (cap_wdata_i),
    .cmd_i       (cmd_i),
    .now_i       (now_i),
    .req_bytes_i (req_bytes_i),
    .res_id_i    (res_id_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .status_o    (status_o),
    .granted_id_o(granted_id_o),
    .avg_bytes_o (avg_bytes_o),
    .util_ratio_o(util_ratio_o),
    .free_bytes_o(free_bytes_o)
  );

endmodule

@@ dv/capacity_reservation_tracker_core_test.sv @@
// ----------------------------------------------------------------------------
// capacity_reservation_tracker_core_test
// Drives reserve, release and profile commands into the tracker core. A local
// occupancy model predicts every result beat, and a monitor checks each done_o
// beat against the oldest prediction. The capacity register is rewritten only
// while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module capacity_reservation_tracker_core_test;
  import crt_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_id;
    logic [31:0] avg_bytes;
    logic [16:0] util_ratio;
    logic [31:0] free_bytes;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cap_we = 1'b0;
  logic [31:0] cap_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = CMD_RESERVE;
  logic [31:0] now_tick = '0;
  logic [31:0] req_bytes = '0;
  logic [31:0] res_id = '0;
  logic        done;
  beat_t       dut_beat;

  always #4 clk = ~clk;

  capacity_reservation_tracker_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cap_we_i     (cap_we),
    .cap_wdata_i  (cap_wdata),
    .start_i      (start),
    .busy_o       (busy),
    .cmd_i        (cmd),
    .now_i        (now_tick),
    .req_bytes_i  (req_bytes),
    .res_id_i     (res_id),
    .done_o       (done),
    .status_o     (dut_beat.status),
    .granted_id_o (dut_beat.granted_id),
    .avg_bytes_o  (dut_beat.avg_bytes),
    .util_ratio_o (dut_beat.util_ratio),
    .free_bytes_o (dut_beat.free_bytes)
  );

  // occupancy model
  logic [31:0] capacity;
  logic [31:0] slot_id [NUM_SLOTS];
  logic [31:0] slot_start [NUM_SLOTS];
  logic [31:0] slot_bytes [NUM_SLOTS];
  int          live_count;
  logic [31:0] in_use;
  logic [63:0] tick_integral;
  logic [31:0] last_profile;
  logic [31:0] id_counter;

  beat_t       pending_beats [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;
  logic [31:0] clock_tick = '0;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] free_space();
    return (in_use > capacity) ? '0 : capacity - in_use;
  endfunction

  function automatic logic [63:0] slot_ticks(int k, logic [31:0] t);
    logic [31:0] from;
    from = (last_profile > slot_start[k]) ? last_profile : slot_start[k];
    if (t <= from) return '0;
    return 64'(t - from) * 64'(slot_bytes[k]);
  endfunction

  function automatic beat_t predict_occupancy(logic [1:0] c, logic [31:0] t,
                                              logic [31:0] req, logic [31:0] rid);
    beat_t b;
    int k;
    logic [63:0] total;
    logic [63:0] q;
    logic [63:0] r;
    b = '0;
    b.status = ST_OK;
    if (c == CMD_RESERVE) begin
      if (req > free_space()) begin
        b.status = ST_NO_CAP;
      end else if (live_count >= NUM_SLOTS) begin
        b.status = ST_FULL;
      end else begin
        b.granted_id = id_counter;
        slot_id[live_count] = id_counter;
        slot_start[live_count] = t;
        slot_bytes[live_count] = req;
        live_count++;
        id_counter++;
        in_use += req;
      end
    end else if (c == CMD_RELEASE) begin
      k = 0;
      while (k < live_count && slot_id[k] != rid) k++;
      if (k == live_count) begin
        b.status = ST_NOT_FOUND;
      end else begin
        tick_integral = add_sat(tick_integral, slot_ticks(k, t));
        in_use = (slot_bytes[k] > in_use) ? '0 : in_use - slot_bytes[k];
        slot_id[k] = slot_id[live_count - 1];
        slot_start[k] = slot_start[live_count - 1];
        slot_bytes[k] = slot_bytes[live_count - 1];
        live_count--;
      end
    end else if (c == CMD_PROFILE) begin
      if (t <= last_profile) begin
        b.status = ST_EMPTY;
      end else begin
        total = tick_integral;
        for (k = 0; k < live_count; k++) total = add_sat(total, slot_ticks(k, t));
        q = total / 64'(t - last_profile);
        b.avg_bytes = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
        if (capacity == 0) begin
          b.util_ratio = 17'd65536;
        end else begin
          r = {b.avg_bytes, 16'd0} / 64'(capacity);
          b.util_ratio = (r > 64'd65536) ? 17'd65536 : r[16:0];
        end
        tick_integral = '0;
        last_profile = t;
      end
    end
    b.free_bytes = free_space();
    return b;
  endfunction

  task automatic random_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  task automatic send_command(logic [1:0] c, logic [31:0] t, logic [31:0] req,
                              logic [31:0] rid);
    random_gap();
    start <= 1'b1;
    cmd <= c;
    now_tick <= t;
    req_bytes <= req;
    res_id <= rid;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_beats.push_back(predict_occupancy(c, t, req, rid));
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // time advances by small random steps, occasionally jumps or goes back
  task automatic send_at_step(logic [1:0] c, logic [31:0] req, logic [31:0] rid);
    case ($urandom_range(0, 19))
      0: clock_tick = clock_tick - $urandom_range(0, 50);
      1: clock_tick = clock_tick + $urandom;
      default: clock_tick = clock_tick + $urandom_range(0, 300);
    endcase
    send_command(c, clock_tick, req, rid);
  endtask

  task automatic write_capacity(logic [31:0] value);
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cap_we <= 1'b1;
    cap_wdata <= value;
    @(negedge clk);
    cap_we <= 1'b0;
    capacity = value;
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (done) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat status=%0d", dut_beat.status);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (dut_beat.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, dut_beat.status);
          fail_count++;
        end
        if (dut_beat.granted_id !== want.granted_id) begin
          $error("granted_id exp %0h got %0h", want.granted_id, dut_beat.granted_id);
          fail_count++;
        end
        if (dut_beat.avg_bytes !== want.avg_bytes) begin
          $error("avg_bytes exp %0h got %0h", want.avg_bytes, dut_beat.avg_bytes);
          fail_count++;
        end
        if (dut_beat.util_ratio !== want.util_ratio) begin
          $error("util_ratio exp %0h got %0h", want.util_ratio, dut_beat.util_ratio);
          fail_count++;
        end
        if (dut_beat.free_bytes !== want.free_bytes) begin
          $error("free_bytes exp %0h got %0h", want.free_bytes, dut_beat.free_bytes);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cap_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] live_or_stale_id();
    if (live_count != 0 && $urandom_range(0, 4) != 0)
      return slot_id[$urandom_range(0, live_count - 1)];
    return id_counter - $urandom_range(0, 80);
  endfunction

  task automatic test_directed_edges();
    clock_tick = 32'd10;
    send_command(CMD_PROFILE, '0, '0, '0);
    send_command(CMD_RESERVE, 32'd5, '1, '0);
    send_command(CMD_RESERVE, 32'd5, '0, '1);
    send_command(CMD_RESERVE, 32'd6, 32'h4000_0000, '0);
    send_command(CMD_RESERVE, 32'd7, 32'd1, '0);
    send_command(CMD_RELEASE, 32'd8, '0, 32'hDEAD_BEEF);
    send_command(CMD_PROFILE, 32'd100, '0, '0);
    send_command(CMD_PROFILE, 32'd100, '0, '0);
    send_command(2'd3, 32'd101, '1, '1);
    send_command(CMD_RELEASE, 32'd50, '0, 32'd1);
    send_command(CMD_RELEASE, 32'd200, '0, 32'd0);
    send_command(CMD_PROFILE, 32'hFFFF_FFFF, '0, '0);
    clock_tick = '1;
  endtask

  task automatic test_full_table();
    int i;
    write_capacity('1);
    for (i = 0; i < NUM_SLOTS + 2; i++) send_at_step(CMD_RESERVE, $urandom_range(0, 1000), '0);
    send_at_step(CMD_RESERVE, '1, '0);
    send_at_step(CMD_PROFILE, '0, '0);
    for (i = 0; i < NUM_SLOTS + 2; i++) send_at_step(CMD_RELEASE, '0, live_or_stale_id());
  endtask

  task automatic test_capacity_below_usage();
    write_capacity(32'h8000_0000);
    send_at_step(CMD_RESERVE, 32'h7000_0000, '0);
    write_capacity(32'd1);
    send_at_step(CMD_RESERVE, 32'd1, '0);
    send_at_step(CMD_RESERVE, '0, '0);
    send_at_step(CMD_PROFILE, '0, '0);
    write_capacity('0);
    send_at_step(CMD_PROFILE, '0, '0);
    send_at_step(CMD_RELEASE, '0, slot_id[0]);
  endtask

  task automatic test_random_traffic(int count, bit with_gaps);
    int i;
    logic [31:0] req;
    gaps_on = with_gaps;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: req = $urandom;
        1: req = $urandom_range(0, 1);
        default: req = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_at_step(CMD_RESERVE, req, $urandom);
        4, 5, 6: send_at_step(CMD_RELEASE, $urandom, live_or_stale_id());
        7, 8: send_at_step(CMD_PROFILE, $urandom, $urandom);
        default: send_at_step(2'd3, $urandom, $urandom);
      endcase
    end
  endtask

  task automatic test_id_wrap();
    int i;
    // churn reserve/release pairs, each releasing the most recently granted id
    for (i = 0; i < 40; i++) begin
      send_at_step(CMD_RESERVE, $urandom_range(0, 9), '0);
      send_at_step(CMD_RELEASE, '0, id_counter - 1);
    end
  endtask

  initial begin
    capacity = CAP_RESET;
    live_count = 0;
    in_use = '0;
    tick_integral = '0;
    last_profile = '0;
    id_counter = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_edges();
    test_full_table();
    test_capacity_below_usage();
    write_capacity($urandom_range(1, 5000));
    test_random_traffic(400, 1'b1);
    write_capacity($urandom);
    test_id_wrap();
    test_random_traffic(500, 1'b1);
    write_capacity('1);
    test_random_traffic(300, 1'b1);
    write_capacity(CAP_RESET);
    test_random_traffic(300, 1'b0);
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
